/* design/box_filter_half_downscaler_macros.svh */
// assertion macros for the downscaler rtl
`ifndef BOX_FILTER_HALF_DOWNSCALER_MACROS_SVH
`define BOX_FILTER_HALF_DOWNSCALER_MACROS_SVH

// same-cycle implication, checked outside reset
`define BFHD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define BFHD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/bfhd_pkg.sv */
// package: shared constants and control types of the downscaler
`default_nettype none

package bfhd_pkg;

   localparam int PIXEL_BITS_DEF  = 8;
   localparam int LINE_LENGTH_DEF = 256;
   localparam int FRAME_LINES_DEF = 256;

   localparam int IN_PIXEL_W  = 8;
   localparam int OUT_COORD_W = 7;
   localparam int OUT_VALUE_W = 8;

   // per-pixel control decoded from the raster position
   typedef struct packed {
      logic pair_done;  // odd column: horizontal pair complete, store write
      logic odd_row;    // odd row: merge with stored value, result is final
   } item_ctl_type;

endpackage

`default_nettype wire

/* design/bfhd_frame_mem.sv */
// half-size frame store: one write port, one registered read port
`default_nettype none

module bfhd_frame_mem #(
   parameter int DEPTH  = 16384,
   parameter int ADDR_W = 14,
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/bfhd_raster_ctr.sv */
// raster position tracker: counters, previous pixel, horizontal mean, store address
`default_nettype none

module bfhd_raster_ctr #(
   parameter int PIXEL_BITS  = 8,
   parameter int LINE_LENGTH = 256,
   parameter int FRAME_LINES = 256,
   parameter int HALF_WIDTH  = 128,
   parameter int ADDR_W      = 14,
   parameter int HCOL_W      = 7,
   parameter int HROW_W      = 7
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic [bfhd_pkg::IN_PIXEL_W-1:0] pixel_value,
   output bfhd_pkg::item_ctl_type             ctl,
   output logic      [HCOL_W-1:0]             hcol,
   output logic      [HROW_W-1:0]             hrow,
   output logic      [ADDR_W-1:0]             addr,
   output logic      [PIXEL_BITS-1:0]         horiz
);

   import bfhd_pkg::*;

   localparam int COL_W = (LINE_LENGTH > 2) ? $clog2(LINE_LENGTH) : 1;
   localparam int ROW_W = (FRAME_LINES > 2) ? $clog2(FRAME_LINES) : 1;

   logic [COL_W-1:0]      col_ff,  col_in;
   logic [ROW_W-1:0]      row_ff,  row_in;
   logic [ADDR_W-1:0]     base_ff, base_in;
   logic [PIXEL_BITS-1:0] prev_ff;
   logic [PIXEL_BITS-1:0] pix;
   logic [PIXEL_BITS:0]   pair_sum;
   logic                  line_end;
   logic                  frame_end;

   assign pix       = PIXEL_BITS'(pixel_value);
   assign pair_sum  = {1'b0, prev_ff} + {1'b0, pix};
   assign horiz     = pair_sum[PIXEL_BITS:1];
   assign line_end  = (col_ff == COL_W'(LINE_LENGTH - 1));
   assign frame_end = (row_ff == ROW_W'(FRAME_LINES - 1));

   assign ctl.pair_done = col_ff[0];
   assign ctl.odd_row   = row_ff[0];
   assign hcol          = HCOL_W'(col_ff >> 1);
   assign hrow          = HROW_W'(row_ff >> 1);
   // base_ff tracks hrow * HALF_WIDTH without a multiplier
   assign addr          = base_ff + ADDR_W'(hcol);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      base_in = base_ff;
      if (advance) begin
         if (line_end) begin
            col_in = '0;
            if (frame_end) begin
               row_in  = '0;
               base_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
               if (row_ff[0]) begin
                  base_in = base_ff + ADDR_W'(HALF_WIDTH);
               end
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         base_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         base_ff <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prev_ff <= pix;
      end
   end

endmodule

`default_nettype wire

/* design/box_filter_half_downscaler.sv */
// top level: 2x2 box-filter downscaler around a half-size frame store
//
//  - req channel carries one pixel per transfer in raster order, starting at
//    column 0 of row 0 after reset; columns wrap at LINE_LENGTH, rows at
//    FRAME_LINES
//  - every odd-column pixel produces one rsp transfer: the store entry just
//    written, with halved coordinates; is_final marks the completed 2x2 mean
//    of an odd row, otherwise the value is the partial mean of the pixel pair
//  - even-column pixels produce no rsp transfer
//  - throughput is one pixel per cycle unless a stalled rsp holds the flow;
//    a req transfer passes the read stage, then the output register,
//    before rsp_valid rises for it
//  - a stalled rsp holds the output register; pixels keep flowing until an
//    odd-column pixel reaches the read stage, then req_ready drops until the
//    output register frees
//  - reset clears the counters and the pipeline valids; the store itself is
//    not cleared, every entry is written on an even row before its odd row
//    reads it back
//  - the store read of a 2x2 block happens a full line after its write, so
//    the read-modify-write needs no forwarding
`default_nettype none
`include "box_filter_half_downscaler_macros.svh"

module box_filter_half_downscaler #(
   parameter int PIXEL_BITS  = bfhd_pkg::PIXEL_BITS_DEF,
   parameter int LINE_LENGTH = bfhd_pkg::LINE_LENGTH_DEF,
   parameter int FRAME_LINES = bfhd_pkg::FRAME_LINES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [bfhd_pkg::IN_PIXEL_W-1:0]  req_pixel_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [bfhd_pkg::OUT_COORD_W-1:0] rsp_out_column,
   output logic      [bfhd_pkg::OUT_COORD_W-1:0] rsp_out_row,
   output logic      [bfhd_pkg::OUT_VALUE_W-1:0] rsp_out_value,
   output logic                                  rsp_is_final
);

   import bfhd_pkg::*;

   localparam int HALF_WIDTH  = (LINE_LENGTH + 1) / 2;
   localparam int HALF_HEIGHT = (FRAME_LINES + 1) / 2;
   localparam int DEPTH       = HALF_WIDTH * HALF_HEIGHT;
   localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int HCOL_W      = (LINE_LENGTH > 2) ? $clog2(LINE_LENGTH) - 1 : 1;
   localparam int HROW_W      = (FRAME_LINES > 2) ? $clog2(FRAME_LINES) - 1 : 1;

   // raster tracker outputs for the pixel at the req port
   item_ctl_type          trk_ctl;
   logic [HCOL_W-1:0]     trk_hcol;
   logic [HROW_W-1:0]     trk_hrow;
   logic [ADDR_W-1:0]     trk_addr;
   logic [PIXEL_BITS-1:0] trk_horiz;

   // read stage: waits for the store read data
   logic                  s1_valid_ff, s1_valid_in;
   item_ctl_type          s1_ctl_ff;
   logic [HCOL_W-1:0]     s1_hcol_ff;
   logic [HROW_W-1:0]     s1_hrow_ff;
   logic [ADDR_W-1:0]     s1_addr_ff;
   logic [PIXEL_BITS-1:0] s1_horiz_ff;

   // output register
   logic                   out_valid_ff, out_valid_in;
   logic [OUT_COORD_W-1:0] out_col_ff;
   logic [OUT_COORD_W-1:0] out_row_ff;
   logic [OUT_VALUE_W-1:0] out_value_ff;
   logic                   out_final_ff;

   logic                  accept;
   logic                  s1_adv;
   logic                  rd_en;
   logic                  wr_en;
   logic [PIXEL_BITS-1:0] rd_data;
   logic [PIXEL_BITS:0]   merge_sum;
   logic [PIXEL_BITS-1:0] new_value;

   // read stage moves on unless its result has nowhere to go
   assign s1_adv    = s1_valid_ff &&
                      (!s1_ctl_ff.pair_done || !out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   // only odd-row pairs need the stored partial mean
   assign rd_en = accept && trk_ctl.pair_done && trk_ctl.odd_row;
   assign wr_en = s1_adv && s1_ctl_ff.pair_done;

   assign merge_sum = {1'b0, rd_data} + {1'b0, s1_horiz_ff};
   assign new_value = s1_ctl_ff.odd_row ? merge_sum[PIXEL_BITS:1] : s1_horiz_ff;

   bfhd_raster_ctr #(
      .PIXEL_BITS  (PIXEL_BITS),
      .LINE_LENGTH (LINE_LENGTH),
      .FRAME_LINES (FRAME_LINES),
      .HALF_WIDTH  (HALF_WIDTH),
      .ADDR_W      (ADDR_W),
      .HCOL_W      (HCOL_W),
      .HROW_W      (HROW_W)
   ) u_raster_ctr (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .pixel_value (req_pixel_value),
      .ctl         (trk_ctl),
      .hcol        (trk_hcol),
      .hrow        (trk_hrow),
      .addr        (trk_addr),
      .horiz       (trk_horiz)
   );

   bfhd_frame_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (PIXEL_BITS)
   ) u_frame_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (trk_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (new_value)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (wr_en) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff   <= trk_ctl;
         s1_hcol_ff  <= trk_hcol;
         s1_hrow_ff  <= trk_hrow;
         s1_addr_ff  <= trk_addr;
         s1_horiz_ff <= trk_horiz;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         out_col_ff   <= OUT_COORD_W'(s1_hcol_ff);
         out_row_ff   <= OUT_COORD_W'(s1_hrow_ff);
         out_value_ff <= OUT_VALUE_W'(new_value);
         out_final_ff <= s1_ctl_ff.odd_row;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_column = out_col_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_out_value  = out_value_ff;
   assign rsp_is_final   = out_final_ff;

   // a store write always lands in the output register
   `BFHD_ASSERT_NEXT(a_write_shows, clock, reset, wr_en, rsp_valid, "write not presented")
   // a stalled read stage blocks new pixels
   `BFHD_ASSERT_NOW(a_stall_blocks, clock, reset, s1_valid_ff && !s1_adv, !req_ready, "stall leak")
   // a write never overruns a waiting result
   `BFHD_ASSERT_NOW(a_no_overrun, clock, reset, wr_en && out_valid_ff, rsp_ready, "output overrun")
   // an accepted pixel always occupies the read stage next
   `BFHD_ASSERT_NEXT(a_accept_fills, clock, reset, accept, s1_valid_ff, "pixel lost")

endmodule

`default_nettype wire
